/* sv/msd_pkg.sv */
// Shared types and constants for the pointer shake detector.
package msd_pkg;

   localparam int RING_DEPTH_DFLT = 64;
   localparam int TS_W            = 32;
   localparam int X_W             = 16;
   localparam int REV_W           = 6;
   localparam int MIN_SAMPLES     = 6;
   localparam int SLOW_GAP_MS     = 200;
   localparam int MS_PER_S        = 1000;
   localparam int REV_MAX         = 63;
   localparam int SPEED_W         = 10;
   localparam int MINREV_W        = 3;
   localparam int WIN_W           = 14;
   localparam int COOL_W          = 14;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 14;
   localparam int LHS_W           = 26;
   localparam int RHS_W           = SPEED_W + TS_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_SPEED     = 2'd0,
      CSR_MIN_REVERSALS = 2'd1,
      CSR_WINDOW_MS     = 2'd2,
      CSR_COOLDOWN_MS   = 2'd3
   } csr_index_type;

   localparam logic [SPEED_W-1:0]  MIN_SPEED_RST     = 10'd500;
   localparam logic [MINREV_W-1:0] MIN_REVERSALS_RST = 3'd4;
   localparam logic [WIN_W-1:0]    WINDOW_MS_RST     = 14'd500;
   localparam logic [COOL_W-1:0]   COOLDOWN_MS_RST   = 14'd1000;

   typedef struct packed {
      logic [SPEED_W-1:0]  speed_floor;
      logic [MINREV_W-1:0] rev_goal;
      logic [WIN_W-1:0]    age_limit;
      logic [COOL_W-1:0]   quiet_ms;
   } cfg_type;

   typedef struct packed {
      logic [TS_W-1:0] ts;
      logic [X_W-1:0]  x;
   } ring_entry_type;

   // clear starts a walk; valid/first/last tag the ring read data of this cycle
   typedef struct packed {
      logic clear;
      logic valid;
      logic first;
      logic last;
   } walk_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESULT
   } seq_state_type;

endpackage

/* sv/msd_ring.sv */
// Sample ring: one write port, one read port with registered read data.
module msd_ring #(
   parameter int RING_DEPTH = msd_pkg::RING_DEPTH_DFLT
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(RING_DEPTH)-1:0]  wr_addr,
   input  msd_pkg::ring_entry_type        wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(RING_DEPTH)-1:0]  rd_addr,
   output msd_pkg::ring_entry_type        rd_data
);
   import msd_pkg::*;

   ring_entry_type mem [RING_DEPTH];
   ring_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/msd_pair_eval.sv */
// Pair evaluation pipeline: differences and cross-multiply, then reversal tracking.
module msd_pair_eval (
   input  logic                               clock,
   input  logic                               reset,
   input  msd_pkg::cfg_type                   cfg,
   input  logic [msd_pkg::TS_W-1:0]           now,
   input  msd_pkg::walk_ctl_type              ctl,
   input  msd_pkg::ring_entry_type            rd_data,
   output logic                               done,
   output logic [msd_pkg::REV_W-1:0]          revs
);
   import msd_pkg::*;

   logic [TS_W-1:0]  prev_t_ff;
   logic [X_W-1:0]   prev_x_ff;

   logic [X_W:0]     dx_c;
   logic [X_W:0]     adx_full_c;
   logic [X_W-1:0]   adx_c;
   logic [TS_W-1:0]  dt_c;
   logic [TS_W-1:0]  age_c;

   logic             b_valid_ff;
   logic             b_pair_ff;
   logic             b_last_ff;
   logic             b_win_ff;
   logic             b_dtz_ff;
   logic             b_pos_ff;
   logic [TS_W-1:0]  b_tb_ff;
   logic [LHS_W-1:0] b_lhs_ff;
   logic [RHS_W-1:0] b_rhs_ff;

   logic             fast_seen_ff;
   logic [TS_W-1:0]  fast_time_ff;
   logic             dir_valid_ff;
   logic             dir_right_ff;
   logic [REV_W-1:0] revs_ff;

   logic             fast_c;
   logic             slow_gap_c;

   // stage A
   assign dx_c       = {rd_data.x[X_W-1], rd_data.x} - {prev_x_ff[X_W-1], prev_x_ff};
   assign adx_full_c = dx_c[X_W] ? (~dx_c + 1'b1) : dx_c;
   assign adx_c      = adx_full_c[X_W-1:0];
   assign dt_c       = rd_data.ts - prev_t_ff;
   assign age_c      = now - prev_t_ff;

   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         prev_t_ff <= rd_data.ts;
         prev_x_ff <= rd_data.x;
      end
      b_win_ff <= (age_c <= TS_W'(cfg.age_limit));
      b_dtz_ff <= (dt_c == '0);
      b_pos_ff <= !dx_c[X_W] && (dx_c != '0);
      b_tb_ff  <= rd_data.ts;
      b_lhs_ff <= LHS_W'(adx_c) * LHS_W'(MS_PER_S);
      b_rhs_ff <= RHS_W'(cfg.speed_floor) * RHS_W'(dt_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_pair_ff  <= 1'b0;
         b_last_ff  <= 1'b0;
      end else begin
         b_valid_ff <= ctl.valid;
         b_pair_ff  <= ctl.valid && !ctl.first;
         b_last_ff  <= ctl.valid && ctl.last;
      end
   end

   // stage B
   assign fast_c     = RHS_W'(b_lhs_ff) >= b_rhs_ff;
   assign slow_gap_c = (b_tb_ff - fast_time_ff) > TS_W'(SLOW_GAP_MS);

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_seen_ff <= 1'b0;
         dir_valid_ff <= 1'b0;
         revs_ff      <= '0;
      end else if (ctl.clear) begin
         fast_seen_ff <= 1'b0;
         dir_valid_ff <= 1'b0;
         revs_ff      <= '0;
      end else if (b_pair_ff && b_win_ff && !b_dtz_ff) begin
         if (!fast_c) begin
            if (fast_seen_ff && slow_gap_c) begin
               dir_valid_ff <= 1'b0;
            end
         end else begin
            fast_seen_ff <= 1'b1;
            dir_valid_ff <= 1'b1;
            if (dir_valid_ff && (b_pos_ff != dir_right_ff) &&
                (revs_ff != REV_W'(REV_MAX))) begin
               revs_ff <= revs_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_pair_ff && b_win_ff && !b_dtz_ff && fast_c) begin
         fast_time_ff <= b_tb_ff;
         dir_right_ff <= b_pos_ff;
      end
   end

   assign done = b_valid_ff && b_last_ff;
   assign revs = revs_ff;

endmodule

/* sv/msd_seq.sv */
// Sequencer: request intake, ring pointers, walk address issue, response register.
module msd_seq #(
   parameter int RING_DEPTH = msd_pkg::RING_DEPTH_DFLT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  msd_pkg::cfg_type                   cfg,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [msd_pkg::TS_W-1:0]           req_timestamp_ms,
   input  logic signed [msd_pkg::X_W-1:0]     req_x_position,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_shake_detected,
   output logic [msd_pkg::REV_W-1:0]          rsp_reversal_count,
   output logic                               wr_en,
   output logic [$clog2(RING_DEPTH)-1:0]      wr_addr,
   output msd_pkg::ring_entry_type            wr_data,
   output logic                               rd_en,
   output logic [$clog2(RING_DEPTH)-1:0]      rd_addr,
   output msd_pkg::walk_ctl_type              ctl,
   output logic [msd_pkg::TS_W-1:0]           now,
   input  logic                               done,
   input  logic [msd_pkg::REV_W-1:0]          revs
);
   import msd_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);

   seq_state_type    state_ff, state_in;
   logic [PTR_W-1:0] wp_ff;
   logic [CNT_W-1:0] fill_ff;
   logic [TS_W-1:0]  last_shake_ff;
   logic [TS_W-1:0]  now_ff;
   logic             eval_ff;
   logic [PTR_W-1:0] rd_addr_ff;
   logic [CNT_W-1:0] left_ff;
   logic             first_ff;
   logic             tag_valid_ff;
   logic             tag_first_ff;
   logic             tag_last_ff;
   logic             rsp_valid_ff;
   logic             rsp_shake_ff;
   logic [REV_W-1:0] rsp_revs_ff;

   logic             accept;
   logic             issue;
   logic             load_rsp;
   logic             slot_free;
   logic [PTR_W-1:0] wp_new;
   logic [CNT_W-1:0] fill_new;
   logic [CNT_W:0]   start_sum;
   logic [CNT_W:0]   start_wrap;
   logic             eval_c;
   logic             shake_c;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign wp_new    = (wp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign fill_new  = (fill_ff == DEPTH_C) ? fill_ff : fill_ff + 1'b1;
   assign start_sum = (CNT_W+1)'(wp_new) + (CNT_W+1)'(RING_DEPTH) - (CNT_W+1)'(fill_new);
   assign start_wrap = (start_sum >= (CNT_W+1)'(RING_DEPTH)) ?
                       start_sum - (CNT_W+1)'(RING_DEPTH) : start_sum;
   assign eval_c    = ((req_timestamp_ms - last_shake_ff) >= TS_W'(cfg.quiet_ms)) &&
                      (fill_new >= CNT_W'(MIN_SAMPLES));
   assign shake_c   = eval_ff && (revs >= REV_W'(cfg.rev_goal));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = eval_c ? ST_WALK : ST_RESULT;
            end
         end
         ST_WALK: begin
            if (done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_WALK:   issue     = (left_ff != '0);
         ST_RESULT: load_rsp  = slot_free;
         default:   req_ready = 1'b0;
      endcase
   end

   assign accept = req_ready && req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         fill_ff       <= '0;
         last_shake_ff <= '0;
         left_ff       <= '0;
         tag_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_valid_ff <= issue;
         if (accept) begin
            wp_ff   <= wp_new;
            fill_ff <= fill_new;
            left_ff <= eval_c ? fill_new : '0;
         end else if (issue) begin
            left_ff <= left_ff - 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
            if (shake_c) begin
               last_shake_ff <= now_ff;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff     <= req_timestamp_ms;
         eval_ff    <= eval_c;
         rd_addr_ff <= start_wrap[PTR_W-1:0];
         first_ff   <= 1'b1;
      end else if (issue) begin
         rd_addr_ff <= (rd_addr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_addr_ff + 1'b1;
         first_ff   <= 1'b0;
      end
      tag_first_ff <= first_ff;
      tag_last_ff  <= (left_ff == CNT_W'(1));
      if (load_rsp) begin
         rsp_shake_ff <= shake_c;
         rsp_revs_ff  <= eval_ff ? revs : '0;
      end
   end

   assign wr_en   = accept;
   assign wr_addr = wp_ff;
   assign wr_data = '{ts: req_timestamp_ms, x: req_x_position};
   assign rd_en   = issue;
   assign rd_addr = rd_addr_ff;
   assign now     = now_ff;

   assign ctl.clear = accept;
   assign ctl.valid = tag_valid_ff;
   assign ctl.first = tag_first_ff;
   assign ctl.last  = tag_last_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_shake_detected = rsp_shake_ff;
   assign rsp_reversal_count = rsp_revs_ff;

endmodule

/* sv/motion_shake_detector.sv */
// Pointer shake detector top level: config registers and block wiring.
//
//  channel   ports                                       direction
//  req       req_valid/req_ready, timestamp_ms, x_pos    in
//  rsp       rsp_valid/rsp_ready, shake_detected, count  out
//  csr       csr_we, csr_index, csr_wdata                in, write only
//
// An evaluated request walks the ring with one read per stored sample on the
// single read port, then waits for pipeline fill and result.
// A request skipped by cooldown or too few samples goes straight to the result.
// Reset empties the ring logically (fill count zero); no clearing pass.
// A new request is taken while an earlier response still waits in its register;
// a walk finishing with that register still full holds until it drains.
module motion_shake_detector #(
   parameter int RING_DEPTH = msd_pkg::RING_DEPTH_DFLT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [msd_pkg::TS_W-1:0]              req_timestamp_ms,
   input  logic signed [msd_pkg::X_W-1:0]        req_x_position,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_shake_detected,
   output logic [msd_pkg::REV_W-1:0]             rsp_reversal_count,
   input  logic                                  csr_we,
   input  logic [msd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [msd_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import msd_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);

   cfg_type          cfg_ff;
   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   ring_entry_type   wr_data;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;
   ring_entry_type   rd_data;
   walk_ctl_type     ctl;
   logic [TS_W-1:0]  now;
   logic             done;
   logic [REV_W-1:0] revs;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_floor <= MIN_SPEED_RST;
         cfg_ff.rev_goal    <= MIN_REVERSALS_RST;
         cfg_ff.age_limit   <= WINDOW_MS_RST;
         cfg_ff.quiet_ms    <= COOLDOWN_MS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_SPEED:     cfg_ff.speed_floor <= csr_wdata[SPEED_W-1:0];
            CSR_MIN_REVERSALS: cfg_ff.rev_goal    <= csr_wdata[MINREV_W-1:0];
            CSR_WINDOW_MS:     cfg_ff.age_limit   <= csr_wdata[WIN_W-1:0];
            CSR_COOLDOWN_MS:   cfg_ff.quiet_ms    <= csr_wdata[COOL_W-1:0];
            default:           cfg_ff             <= cfg_ff;
         endcase
      end
   end

   msd_seq #(
      .RING_DEPTH(RING_DEPTH)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_timestamp_ms  (req_timestamp_ms),
      .req_x_position    (req_x_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_shake_detected(rsp_shake_detected),
      .rsp_reversal_count(rsp_reversal_count),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .ctl               (ctl),
      .now               (now),
      .done              (done),
      .revs              (revs)
   );

   msd_ring #(
      .RING_DEPTH(RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   msd_pair_eval u_pair_eval (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .now    (now),
      .ctl    (ctl),
      .rd_data(rd_data),
      .done   (done),
      .revs   (revs)
   );

endmodule

/* dv/motion_shake_detector_tb.sv */
// Self-checking testbench for motion_shake_detector with a built-in shake predictor.
module motion_shake_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msd_pkg::*;

   localparam int DEPTH = RING_DEPTH_DFLT;
   localparam int LIMIT = 2_000_000;

   typedef struct packed {
      logic             shake;
      logic [REV_W-1:0] revs;
   } shake_verdict_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [TS_W-1:0]       req_timestamp_ms = '0;
   logic signed [X_W-1:0] req_x_position = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_shake_detected;
   logic [REV_W-1:0]      rsp_reversal_count;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   motion_shake_detector dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_timestamp_ms   (req_timestamp_ms),
      .req_x_position     (req_x_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_shake_detected (rsp_shake_detected),
      .rsp_reversal_count (rsp_reversal_count),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [TS_W-1:0]       ring_ts [DEPTH];
   logic signed [X_W-1:0] ring_x [DEPTH];
   int                    wr_ptr;
   int                    fill;
   logic [TS_W-1:0]       last_shake_ts;
   logic [SPEED_W-1:0]    speed_lim;
   logic [MINREV_W-1:0]   rev_goal;
   logic [WIN_W-1:0]      window_lim;
   logic [COOL_W-1:0]     cool_lim;

   shake_verdict_type pending[$];
   shake_verdict_type expected_head;
   int             mismatch_count = 0;
   int             requests_sent = 0;
   int             shakes_predicted = 0;
   int             settings_count = 0;
   int             cycle_count = 0;
   bit             req_gaps_on = 1'b1;
   logic [TS_W-1:0] cur_ts = '0;
   int             cur_x = 0;

   function automatic void reset_predictor();
      wr_ptr = 0;
      fill = 0;
      last_shake_ts = '0;
      speed_lim = MIN_SPEED_RST;
      rev_goal = MIN_REVERSALS_RST;
      window_lim = WINDOW_MS_RST;
      cool_lim = COOLDOWN_MS_RST;
   endfunction

   function automatic logic [REV_W-1:0] tally_reversals(input logic [TS_W-1:0] now);
      int                base, a, b, dx, adx, dir, heading;
      logic [TS_W-1:0]   ta, tb, dt, fast_ts;
      longint unsigned   adx_scaled, speed_scaled;
      bit                fast_seen;
      logic [REV_W-1:0]  revs;
      base = (wr_ptr + DEPTH - fill) % DEPTH;
      revs = '0;
      dir = 0;
      fast_seen = 1'b0;
      fast_ts = '0;
      for (int i = 1; i < fill; i++) begin
         a = (base + i - 1) % DEPTH;
         b = (base + i) % DEPTH;
         ta = ring_ts[a];
         tb = ring_ts[b];
         if (now - ta > window_lim) continue;
         dt = tb - ta;
         if (dt == 0) continue;
         dx = int'(ring_x[b]) - int'(ring_x[a]);
         adx = (dx < 0) ? -dx : dx;
         adx_scaled = longint'(adx) * MS_PER_S;
         speed_scaled = longint'(speed_lim) * longint'(dt);
         if (adx_scaled < speed_scaled) begin
            if (fast_seen && (tb - fast_ts) > SLOW_GAP_MS) dir = 0;
            continue;
         end
         fast_seen = 1'b1;
         fast_ts = tb;
         heading = (dx > 0) ? 1 : -1;
         if (dir != 0 && heading != dir && revs < REV_MAX) revs++;
         dir = heading;
      end
      return revs;
   endfunction

   function automatic shake_verdict_type predict_motion(input logic [TS_W-1:0] now,
                                                        input logic signed [X_W-1:0] x);
      shake_verdict_type v;
      v = '0;
      ring_ts[wr_ptr] = now;
      ring_x[wr_ptr] = x;
      wr_ptr = (wr_ptr + 1) % DEPTH;
      if (fill < DEPTH) fill++;
      if (now - last_shake_ts >= cool_lim && fill >= MIN_SAMPLES) begin
         v.revs = tally_reversals(now);
         if (v.revs >= rev_goal) begin
            v.shake = 1'b1;
            last_shake_ts = now;
         end
      end
      return v;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   // response side back-pressure, with stretches of none
   int stall_left = 0;
   int mode_left = 0;
   bit stalls_on = 1'b1;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stalls_on = ($urandom_range(0, 3) != 0);
         mode_left = $urandom_range(50, 400);
      end else begin
         mode_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
         stall_left = pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            expected_head = pending.pop_front();
            if (rsp_shake_detected !== expected_head.shake) begin
               $error("shake_detected: expected %0d, got %0d",
                      expected_head.shake, rsp_shake_detected);
               mismatch_count++;
            end
            if (rsp_reversal_count !== expected_head.revs) begin
               $error("reversal_count: expected %0d, got %0d",
                      expected_head.revs, rsp_reversal_count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d responses outstanding", LIMIT, pending.size());
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_motion(input logic [TS_W-1:0] ts, input logic signed [X_W-1:0] x);
      shake_verdict_type v;
      int idle;
      idle = req_gaps_on ? pick_gap() : 0;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_timestamp_ms <= ts;
      req_x_position <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      v = predict_motion(ts, x);
      pending.push_back(v);
      requests_sent++;
      if (v.shake) shakes_predicted++;
   endtask

   task automatic step_motion(input int dt, input int dx);
      int nx;
      cur_ts = cur_ts + dt;
      nx = cur_x + dx;
      if (nx > 32767 || nx < -32768) nx = cur_x - dx;
      cur_x = nx;
      send_motion(cur_ts, 16'(cur_x));
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_MIN_SPEED:     speed_lim = value[SPEED_W-1:0];
         CSR_MIN_REVERSALS: rev_goal = value[MINREV_W-1:0];
         CSR_WINDOW_MS:     window_lim = value[WIN_W-1:0];
         CSR_COOLDOWN_MS:   cool_lim = value[COOL_W-1:0];
         default:           ;
      endcase
   endtask

   task automatic program_thresholds(input logic [CSR_DATA_W-1:0] speed, minrev, win, cool);
      write_csr(CSR_MIN_SPEED, speed);
      write_csr(CSR_MIN_REVERSALS, minrev);
      write_csr(CSR_WINDOW_MS, win);
      write_csr(CSR_COOLDOWN_MS, cool);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // zigzag gestures with random content, plus jumps, wraps and wild positions
   task automatic run_motion_traffic(input int n_items);
      int sent, n, heading, stroke_len, step_max, kind;
      sent = 0;
      while (sent < n_items) begin
         req_gaps_on = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 2))
               0: step_max = 1;
               1: step_max = 15;
               default: step_max = 40;
            endcase
            n = $urandom_range(8, 30);
            heading = $urandom_range(0, 1) ? 1 : -1;
            stroke_len = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 19) == 0)
                  step_motion($urandom_range(150, 400), heading * $urandom_range(0, 3));
               else
                  step_motion($urandom_range(0, step_max), heading * $urandom_range(0, 400));
               stroke_len--;
               if (stroke_len == 0) begin
                  heading = -heading;
                  stroke_len = $urandom_range(1, 3);
               end
               sent++;
            end
         end else begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
               kind = $urandom_range(0, 4);
               case (kind)
                  0: begin
                     cur_x = $urandom_range(0, 65535) - 32768;
                     cur_ts = cur_ts + $urandom_range(0, 20);
                  end
                  1: cur_ts = cur_ts + $urandom_range(1000, 30000);
                  2: cur_ts = $urandom();
                  3: cur_ts = 32'hFFFF_FFFF - $urandom_range(0, 300);
                  default: begin
                     cur_x = $urandom_range(0, 1) ? 32767 : -32768;
                     cur_ts = cur_ts + $urandom_range(0, 5);
                  end
               endcase
               send_motion(cur_ts, 16'(cur_x));
               sent++;
            end
         end
      end
   endtask

   // reset settings: startup cooldown, equal timestamps, position extremes,
   // a shake followed by cooldown, and a timestamp wrap
   task automatic test_directed_defaults();
      logic [TS_W-1:0] ts_list [19] = '{
         32'd0, 32'd5, 32'd10, 32'd10, 32'd20, 32'd30, 32'd999, 32'd1000, 32'd1010,
         32'd1020, 32'd1030, 32'd1040, 32'd1050, 32'hFFFF_FFF0, 32'hFFFF_FFFA,
         32'd2, 32'd12, 32'd22, 32'd32};
      int x_list [19] = '{
         0, 32767, -32768, 32767, -32768, 32767, 0, 100, -100,
         100, -100, 100, -100, 0, 300, -300, 300, -300, 300};
      for (int i = 0; i < 19; i++) send_motion(ts_list[i], 16'(x_list[i]));
      cur_ts = ts_list[18];
      cur_x = x_list[18];
   endtask

   // masked speed of zero, zero reversal goal, oversize window, no cooldown
   task automatic test_zero_thresholds();
      logic [TS_W-1:0] ts_list [6] = '{32'd40, 32'd50, 32'd50, 32'd60, 32'd70, 32'd80};
      int x_list [6] = '{900, 900, 900, 900, -32768, 32767};
      drain_responses();
      program_thresholds(14'h0400, 14'd0, 14'h3FFF, 14'd0);
      for (int i = 0; i < 6; i++) send_motion(ts_list[i], 16'(x_list[i]));
      cur_ts = ts_list[5];
      cur_x = x_list[5];
   endtask

   task automatic test_config_extremes();
      drain_responses();
      program_thresholds(14'd100, 14'd2, 14'd10000, 14'd0);
      run_motion_traffic(150);
      drain_responses();
      program_thresholds(14'd1000, 14'd6, 14'd1, 14'd10000);
      run_motion_traffic(150);
      drain_responses();
      program_thresholds(14'h2C00, 14'h3FFF, 14'h3FFF, 14'h3FFF);
      run_motion_traffic(150);
      drain_responses();
      program_thresholds(14'h3FFF, 14'd0, 14'd0, 14'd0);
      run_motion_traffic(150);
   endtask

   task automatic test_random_settings();
      logic [CSR_DATA_W-1:0] win, cool;
      for (int s = 0; s < 5; s++) begin
         win = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom_range(1, 10000))
                                            : CSR_DATA_W'($urandom_range(30, 1500));
         cool = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom_range(0, 10000))
                                             : CSR_DATA_W'($urandom_range(0, 3000));
         drain_responses();
         program_thresholds(CSR_DATA_W'($urandom_range(100, 1000)),
                            CSR_DATA_W'($urandom_range(2, 6)), win, cool);
         run_motion_traffic(140);
      end
   endtask

   initial begin
      reset_predictor();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_defaults();
      test_zero_thresholds();
      test_config_extremes();
      test_random_settings();
      drain_responses();
      repeat (80) @(posedge clock);
      $display("Checked %0d motion requests across %0d register settings, %0d shakes flagged",
               requests_sent, settings_count, shakes_predicted);
      $display("Included startup cooldown, timestamp wrap, equal timestamps and zero thresholds");
      if (mismatch_count == 0 && pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
sv/msd_pkg.sv
sv/msd_ring.sv
sv/msd_pair_eval.sv
sv/msd_seq.sv
sv/motion_shake_detector.sv
dv/motion_shake_detector_tb.sv
